/* src/iqsq_pkg.sv */
// ----------------------------------------------------------------------------
// I/Q sample quantizer package
// Field widths, register map codes and product layout shared by the channel
// interfaces and the quantizer top level.
// ----------------------------------------------------------------------------
package iqsq_pkg;

  // Payload widths
  localparam int unsigned SampleWidth = 32;
  localparam int unsigned WordWidth   = 16;
  localparam int unsigned ByteWidth   = 8;

  // Configuration port layout
  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;

  // Register indexes (byte address = 4 * index)
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t RegWordLength   = 3'd0;
  localparam reg_idx_t RegScaleEnable  = 3'd1;
  localparam reg_idx_t RegScaleConst   = 3'd2;
  localparam reg_idx_t RegGainCorr     = 3'd3;
  localparam reg_idx_t RegSwapIq       = 3'd4;
  localparam reg_idx_t RegInputInt16   = 3'd5;

  // Register reset values
  localparam logic [4:0]  WordLengthRst = 5'd16;
  localparam logic [15:0] ScaleConstRst = 16'h8000;
  localparam logic [15:0] GainCorrRst   = 16'h1000;

  // Legal word length range; anything outside acts as the maximum
  localparam logic [4:0] WordLengthMin = 5'd10;
  localparam logic [4:0] WordLengthMax = 5'd16;

  // Q16.16 sample times Q0 scale times Q4.12 gain carries 28 fraction bits
  localparam int unsigned FracBitsIn   = 16;
  localparam int unsigned FracBitsProd = 28;
  localparam int unsigned ProdWidth    = 64;
  localparam int unsigned QuotWidth    = ProdWidth - FracBitsProd;

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic [ByteWidth-1:0]          byte_t;

endpackage

/* src/iqsq_if.sv */
// ----------------------------------------------------------------------------
// I/Q quantizer stream interfaces
// Valid/ready channels: one carries a complex sample, the other one byte of
// the serialized output with an end-of-sample flag.
// ----------------------------------------------------------------------------
interface iqsq_sample_if;
  import iqsq_pkg::*;

  logic    valid;
  logic    ready;
  sample_t in_phase;
  sample_t quadrature;

  modport source (output valid, output in_phase, output quadrature, input ready);
  modport sink   (input valid, input in_phase, input quadrature, output ready);
endinterface

interface iqsq_byte_if;
  import iqsq_pkg::*;

  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  last_of_sample;

  modport source (output valid, output out_byte, output last_of_sample, input ready);
  modport sink   (input valid, input out_byte, input last_of_sample, output ready);
endinterface

/* src/iq_sample_quantize_serialize_top.sv */
// ----------------------------------------------------------------------------
// I/Q sample quantizer and byte serializer
// Turns each complex sample into two W-bit words and sends them as four bytes.
// ----------------------------------------------------------------------------
// Each accepted sample produces four beats on byte_o: first word high byte,
// first word low byte, second word high, second word low (I first unless
// swap_iq is set), with last_of_sample on the fourth beat. The block sustains
// one sample per four output beats, the four beats the byte serializer needs
// per sample; the three arithmetic stages in front of it take a new sample
// every cycle while they have room, so up to three samples queue behind the
// one being sent. The first byte of a sample is valid once the sample has
// passed stages one, two and three and has been loaded into the serializer.
// Scaled float mode forms the scale times gain product in stage one, the full
// 32x32 product in stage two and saturates in stage three. Configuration must
// only be written while no sample is in flight.
module iq_sample_quantize_serialize_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [iqsq_pkg::AddrWidth-1:0] paddr,
  input  logic [iqsq_pkg::DataWidth-1:0] pwdata,
  output logic [iqsq_pkg::DataWidth-1:0] prdata,
  output logic                         pready,
  // streams
  iqsq_sample_if.sink                  sample_i,
  iqsq_byte_if.source                  byte_o
);
  import iqsq_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [4:0]  word_length_q;
  logic        scale_enable_q;
  logic [15:0] scale_constant_q;
  logic [15:0] gain_correction_q;
  logic        swap_iq_q;
  logic        input_int16_q;

  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  // Write registers on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_length_q     <= WordLengthRst;
      scale_enable_q    <= 1'b0;
      scale_constant_q  <= ScaleConstRst;
      gain_correction_q <= GainCorrRst;
      swap_iq_q         <= 1'b0;
      input_int16_q     <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegWordLength:  word_length_q     <= pwdata[4:0];
        RegScaleEnable: scale_enable_q    <= pwdata[0];
        RegScaleConst:  scale_constant_q  <= pwdata[15:0];
        RegGainCorr:    gain_correction_q <= pwdata[15:0];
        RegSwapIq:      swap_iq_q         <= pwdata[0];
        RegInputInt16:  input_int16_q     <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      RegWordLength:  prdata[4:0]  = word_length_q;
      RegScaleEnable: prdata[0]    = scale_enable_q;
      RegScaleConst:  prdata[15:0] = scale_constant_q;
      RegGainCorr:    prdata[15:0] = gain_correction_q;
      RegSwapIq:      prdata[0]    = swap_iq_q;
      RegInputInt16:  prdata[0]    = input_int16_q;
      default: ;
    endcase
  end

  // Out-of-range word lengths act as 16 bits
  logic [4:0] eff_w;
  assign eff_w = (word_length_q < WordLengthMin || word_length_q > WordLengthMax)
                 ? WordLengthMax : word_length_q;

  // --------------------------------------------------------------------------
  // Quantize one channel: saturate and offset negatives by 2^W
  // --------------------------------------------------------------------------
  function automatic logic [WordWidth-1:0] to_word(
    input logic                 neg,
    input logic [ProdWidth-1:0] prod,
    input logic [15:0]          mag_hi,
    input logic [15:0]          lo,
    input logic                 int_mode,
    input logic                 scale_en,
    input logic [15:0]          s,
    input logic [4:0]           w
  );
    logic [QuotWidth-1:0] q;
    logic [15:0]          one;
    logic [15:0]          m;
    logic [16:0]          full;
    logic [16:0]          pow_w;
    q     = prod[ProdWidth-1:FracBitsProd];
    one   = 16'(17'd1 << (w - 5'd1));
    pow_w = 17'd1 << w;
    m     = '0;
    full  = '0;
    if (int_mode) begin
      full = {1'b0, lo} + (lo[15] ? pow_w : 17'd0);
      return full[15:0];
    end
    if (scale_en) begin
      if (s == 16'd0) begin
        m = '0;
      end else if (neg) begin
        m = (q > QuotWidth'(s)) ? s : q[15:0];
      end else begin
        m = (q > QuotWidth'(s - 16'd1)) ? (s - 16'd1) : q[15:0];
      end
    end else begin
      if (neg) begin
        m = (mag_hi > one) ? one : mag_hi;
      end else begin
        m = (mag_hi > (one - 16'd1)) ? (one - 16'd1) : mag_hi;
      end
    end
    if (neg && m != 16'd0) begin
      full = pow_w - {1'b0, m};
      return full[15:0];
    end
    return m;
  endfunction

  // --------------------------------------------------------------------------
  // Pipeline handshake: a stage moves when empty or when its successor moves
  // --------------------------------------------------------------------------
  logic s1_vld_q, s2_vld_q, s3_vld_q, ser_vld_q;
  logic en1, en2, en3, ser_load, ser_rdy;
  logic [1:0] cnt_q;
  logic       beat_out;

  assign beat_out = byte_o.valid && byte_o.ready;
  assign ser_rdy  = !ser_vld_q || (byte_o.ready && cnt_q == 2'd3);
  assign en3      = !s3_vld_q || ser_rdy;
  assign en2      = !s2_vld_q || en3;
  assign en1      = !s1_vld_q || en2;
  assign ser_load = s3_vld_q && ser_rdy;

  assign sample_i.ready = en1;

  // --------------------------------------------------------------------------
  // Stage 1: magnitudes and scale times gain
  // --------------------------------------------------------------------------
  logic        s1_neg_i_q, s1_neg_q_q;
  logic [31:0] s1_mag_i_q, s1_mag_q_q;
  logic [15:0] s1_lo_i_q, s1_lo_q_q;
  logic [31:0] s1_sg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en1) begin
      s1_vld_q <= sample_i.valid;
    end
  end

  // Take the sample and fold the sign
  always_ff @(posedge clk_i) begin
    if (en1 && sample_i.valid) begin
      s1_neg_i_q <= sample_i.in_phase[31];
      s1_neg_q_q <= sample_i.quadrature[31];
      s1_mag_i_q <= sample_i.in_phase[31] ? (32'd0 - sample_i.in_phase)
                                          : sample_i.in_phase;
      s1_mag_q_q <= sample_i.quadrature[31] ? (32'd0 - sample_i.quadrature)
                                            : sample_i.quadrature;
      s1_lo_i_q  <= sample_i.in_phase[15:0];
      s1_lo_q_q  <= sample_i.quadrature[15:0];
      s1_sg_q    <= 32'(scale_constant_q) * 32'(gain_correction_q);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: full products
  // --------------------------------------------------------------------------
  logic                 s2_neg_i_q, s2_neg_q_q;
  logic [ProdWidth-1:0] s2_prod_i_q, s2_prod_q_q;
  logic [15:0]          s2_hi_i_q, s2_hi_q_q;
  logic [15:0]          s2_lo_i_q, s2_lo_q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en2) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  // Multiply magnitude by scale times gain
  always_ff @(posedge clk_i) begin
    if (en2 && s1_vld_q) begin
      s2_neg_i_q  <= s1_neg_i_q;
      s2_neg_q_q  <= s1_neg_q_q;
      s2_prod_i_q <= ProdWidth'(s1_mag_i_q) * ProdWidth'(s1_sg_q);
      s2_prod_q_q <= ProdWidth'(s1_mag_q_q) * ProdWidth'(s1_sg_q);
      s2_hi_i_q   <= s1_mag_i_q[31:FracBitsIn];
      s2_hi_q_q   <= s1_mag_q_q[31:FracBitsIn];
      s2_lo_i_q   <= s1_lo_i_q;
      s2_lo_q_q   <= s1_lo_q_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: saturate, offset and order the two words
  // --------------------------------------------------------------------------
  logic [WordWidth-1:0] word_i, word_q;
  logic [31:0]          s3_pair_q;

  assign word_i = to_word(s2_neg_i_q, s2_prod_i_q, s2_hi_i_q, s2_lo_i_q,
                          input_int16_q, scale_enable_q, scale_constant_q, eff_w);
  assign word_q = to_word(s2_neg_q_q, s2_prod_q_q, s2_hi_q_q, s2_lo_q_q,
                          input_int16_q, scale_enable_q, scale_constant_q, eff_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en3) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && s2_vld_q) begin
      s3_pair_q <= swap_iq_q ? {word_q, word_i} : {word_i, word_q};
    end
  end

  // --------------------------------------------------------------------------
  // Byte serializer: four beats per sample, high byte first
  // --------------------------------------------------------------------------
  logic [31:0] ser_pair_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_vld_q <= 1'b0;
      cnt_q     <= 2'd0;
    end else if (ser_load) begin
      ser_vld_q <= 1'b1;
      cnt_q     <= 2'd0;
    end else if (beat_out) begin
      ser_vld_q <= (cnt_q != 2'd3);
      cnt_q     <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_load) begin
      ser_pair_q <= s3_pair_q;
    end
  end

  // Pick the byte for the current beat
  always_comb begin
    unique case (cnt_q)
      2'd0:    byte_o.out_byte = ser_pair_q[31:24];
      2'd1:    byte_o.out_byte = ser_pair_q[23:16];
      2'd2:    byte_o.out_byte = ser_pair_q[15:8];
      default: byte_o.out_byte = ser_pair_q[7:0];
    endcase
  end

  assign byte_o.valid          = ser_vld_q;
  assign byte_o.last_of_sample = (cnt_q == 2'd3);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_load |-> (!ser_vld_q || (byte_o.ready && cnt_q == 2'd3)))
    else $error("serializer loaded while a sample was still being sent");

  a_s3_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_vld_q && !en3) |=> (s3_vld_q && $stable(s3_pair_q)))
    else $error("stage three lost or changed a stalled sample");

  a_empty_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_out && cnt_q == 2'd3 && !ser_load) |=> !ser_vld_q)
    else $error("serializer still busy after the last beat");

  a_idle_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ser_vld_q |-> (cnt_q == 2'd0))
    else $error("byte counter not at zero while serializer is empty");

endmodule
